### hdl/dlhp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal length header parser package
// Shared types and character constants for the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dlhp_pkg;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    KIND_DIGIT   = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_CR      = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_SECOND  = 2'd1,
    PH_SWALLOW = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CHAR   = 3'd1,
    ST_NL_FIRST   = 3'd2,
    ST_ZERO_CTX   = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_e;

  // One classified byte as it travels from the front end to the parser.
  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
    logic       last;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] context_length;
    logic [31:0] message_length;
    logic [16:0] header_length;
  } result_t;

endpackage : dlhp_pkg

`default_nettype wire

### hdl/dlhp_front.sv
// ----------------------------------------------------------------------------
// Header parser front end
// Accepts raw bytes and classifies each one before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dlhp_front
  import dlhp_pkg::*;
(
  input  wire logic       in_valid_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_buffer_i,
  output logic            in_stall_o,
  input  wire logic       q_full_i,
  output logic            push_o,
  output entry_t          entry_o
);

  logic is_digit;

  assign is_digit   = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    entry_o.last  = end_of_buffer_i;
    entry_o.digit = 4'(data_byte_i - CH_ZERO);
    if (data_byte_i == CH_LF) begin
      entry_o.kind = KIND_NEWLINE;
    end else if (data_byte_i == CH_CR) begin
      entry_o.kind = KIND_CR;
    end else if (is_digit) begin
      entry_o.kind = KIND_DIGIT;
    end else begin
      entry_o.kind = KIND_OTHER;
    end
  end

endmodule : dlhp_front

`default_nettype wire

### hdl/dlhp_queue.sv
// ----------------------------------------------------------------------------
// Header parser queue
// Short register FIFO that decouples the front end from the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module dlhp_queue
  import dlhp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output entry_t      entry_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

endmodule : dlhp_queue

`default_nettype wire

### hdl/dlhp_back.sv
// ----------------------------------------------------------------------------
// Header parser back end
// Runs the two-field decimal parse on classified bytes and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dlhp_back
  import dlhp_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   empty_i,
  input  wire entry_t entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output result_t     result_o
);

  localparam int unsigned PosW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_BUFFER_BYTES);

  phase_e          phase_q, phase_d;
  logic [31:0]     acc1_q, acc1_d;
  logic [31:0]     acc2_q, acc2_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic            emit;
  logic            clear;
  logic            advance;
  status_e         emit_status;
  logic [31:0]     acc_sel;
  logic [35:0]     acc_next;
  logic            overflow;
  logic [PosW:0]   pos_inc;

  // The output register can load whenever it is empty or being drained.
  assign pop_o   = !empty_i && (!out_valid_q || !out_stall_i);
  assign pos_inc = {1'b0, pos_q} + 1'b1;

  // Shared multiply-by-ten and add for whichever field is being parsed.
  assign acc_sel  = (phase_q == PH_FIRST) ? acc1_q : acc2_q;
  assign acc_next = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
                  + {32'b0, entry_i.digit};
  assign overflow = (acc_next[35:32] != 4'b0);

  // Event decode: does this byte settle the outcome, and how.
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_INCOMPLETE;
    advance     = 1'b0;
    if (pop_o && (phase_q != PH_SWALLOW)) begin
      if (pos_q >= MaxPos) begin
        emit = 1'b1;
      end else begin
        case (entry_i.kind)
          KIND_NEWLINE: begin
            if (phase_q == PH_SECOND) begin
              emit        = 1'b1;
              emit_status = ST_OK;
            end else if (pos_q == '0) begin
              emit        = 1'b1;
              emit_status = ST_NL_FIRST;
            end else if (acc1_q == 32'd0) begin
              emit        = 1'b1;
              emit_status = ST_ZERO_CTX;
            end else begin
              advance = 1'b1;
              emit    = entry_i.last;
            end
          end
          KIND_CR: begin
            emit = entry_i.last;
          end
          KIND_DIGIT: begin
            emit = 1'b1;
            if (overflow) begin
              emit_status = ST_OVERFLOW;
            end else begin
              emit = entry_i.last;
            end
          end
          default: begin
            emit        = 1'b1;
            emit_status = ST_BAD_CHAR;
          end
        endcase
      end
    end
    clear = pop_o && entry_i.last && (emit || (phase_q == PH_SWALLOW));
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (clear) begin
      phase_d = PH_FIRST;
    end else if (emit) begin
      phase_d = PH_SWALLOW;
    end else if (advance) begin
      phase_d = PH_SECOND;
    end
  end

  // Accumulators, position and the output register.
  always_comb begin
    acc1_d      = acc1_q;
    acc2_d      = acc2_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o && (phase_q != PH_SWALLOW) && (pos_q < MaxPos)) begin
      pos_d = pos_inc[PosW-1:0];
      if ((entry_i.kind == KIND_DIGIT) && !overflow) begin
        if (phase_q == PH_FIRST) begin
          acc1_d = acc_next[31:0];
        end else begin
          acc2_d = acc_next[31:0];
        end
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.status = emit_status;
      if (emit_status == ST_OK) begin
        out_d.context_length = acc1_q;
        out_d.message_length = acc2_q;
        out_d.header_length  = 17'(pos_inc);
      end
    end
    if (clear) begin
      acc1_d = '0;
      acc2_d = '0;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      acc1_q      <= '0;
      acc2_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc1_q      <= acc1_d;
      acc2_q      <= acc2_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_ok_has_context: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == ST_OK)) |-> (out_q.context_length != 32'd0))
    else $error("success reported with a zero context length");

  a_error_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK)) |->
      ((out_q.context_length == 32'd0) && (out_q.message_length == 32'd0)
       && (out_q.header_length == 17'd0)))
    else $error("error result carries nonzero lengths");

  a_swallow_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SWALLOW) |-> !emit)
    else $error("result produced while swallowing");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("byte position beyond buffer limit");

endmodule : dlhp_back

`default_nettype wire

### hdl/decimal_length_header_parser_unit.sv
// ----------------------------------------------------------------------------
// Decimal length header parser unit
// Parses two newline-terminated decimal lengths at the head of each buffer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one buffer byte per beat, with end_of_buffer_i
//   set on the final byte. The output channel carries one result beat per
//   buffer: a status code and, on success, the context length, message
//   length and header byte count. Error results carry zero lengths.
//   A byte is classified in the front end and written to a four-entry queue;
//   the parser pops one queued byte per cycle while its output register is
//   empty or being drained, so a settling byte passes through the queue and
//   then the output register before its result is presented on the output.
//   Throughput is one byte per cycle unless a result stalls; the parser step
//   is a multiply-by-ten add with an overflow check on a 32-bit accumulator.
//   When the receiver stalls a valid result, the result stays in the output
//   register and the parser stops popping; the queue takes up to four more
//   bytes, and once it fills, in_stall_o is raised.
//   Reset empties the queue, drops any pending result and starts a new
//   buffer in the first field.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_length_header_parser_unit
  import dlhp_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_buffer_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      context_length_o,
  output logic [31:0]      message_length_o,
  output logic [16:0]      header_length_o
);

  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  entry_t  front_entry;
  entry_t  queue_entry;
  result_t result;

  dlhp_front u_front (
    .in_valid_i      (in_valid_i),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .in_stall_o      (in_stall_o),
    .q_full_i        (q_full),
    .push_o          (push),
    .entry_o         (front_entry)
  );

  dlhp_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .entry_o (queue_entry)
  );

  dlhp_back #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .entry_i     (queue_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign status_o         = result.status;
  assign context_length_o = result.context_length;
  assign message_length_o = result.message_length;
  assign header_length_o  = result.header_length;

endmodule : decimal_length_header_parser_unit

`default_nettype wire

### tb/header_parse_monitor.sv
// ----------------------------------------------------------------------------
// Header parse monitor
// Watches both channels of the header parser, predicts the result of every
// buffer from the accepted bytes and compares each result beat field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module header_parse_monitor
  import dlhp_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] context_length_i,
  input  logic [31:0] message_length_i,
  input  logic [16:0] header_length_i,
  output int          fail_count_o,
  output int          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_e      parse_phase;
  logic [31:0] context_acc;
  logic [31:0] message_acc;
  int unsigned byte_offset;
  result_t     pending_results[$];

  initial begin
    fail_count_o    = 0;
    pending_count_o = 0;
  end

  function automatic void clear_parse_state();
    parse_phase = PH_FIRST;
    context_acc = '0;
    message_acc = '0;
    byte_offset = 0;
  endfunction

  function automatic void settle_result(input status_e st, input logic [31:0] ctx,
                                        input logic [31:0] msg, input logic [16:0] hdr,
                                        input logic last, output result_t res);
    res.status         = st;
    res.context_length = ctx;
    res.message_length = msg;
    res.header_length  = hdr;
    if (last) begin
      clear_parse_state();
    end else begin
      parse_phase = PH_SWALLOW;
    end
  endfunction

  // Advances the parse by one byte; returns 1 when the byte settles the buffer.
  function automatic bit parse_header_byte(input logic [7:0] data, input logic last,
                                           output result_t res);
    int unsigned pos;
    logic [7:0]  digit;
    logic [35:0] widened;
    res = '0;
    pos = byte_offset;
    if (parse_phase == PH_SWALLOW) begin
      if (last) clear_parse_state();
      return 1'b0;
    end
    if (pos >= MAX_BUFFER_BYTES) begin
      settle_result(ST_INCOMPLETE, '0, '0, '0, last, res);
      return 1'b1;
    end
    byte_offset = pos + 1;
    if (data == CH_LF) begin
      if (parse_phase == PH_FIRST) begin
        if (pos == 0) begin
          settle_result(ST_NL_FIRST, '0, '0, '0, last, res);
          return 1'b1;
        end
        if (context_acc == '0) begin
          settle_result(ST_ZERO_CTX, '0, '0, '0, last, res);
          return 1'b1;
        end
        parse_phase = PH_SECOND;
      end else begin
        settle_result(ST_OK, context_acc, message_acc, 17'(pos + 1), last, res);
        return 1'b1;
      end
    end else if (data == CH_CR) begin
      // Carriage returns leave the fields untouched.
    end else if (data >= CH_ZERO && data <= CH_NINE) begin
      digit = data - CH_ZERO;
      if (parse_phase == PH_FIRST) begin
        widened = {4'd0, context_acc} * 36'd10 + {28'd0, digit};
      end else begin
        widened = {4'd0, message_acc} * 36'd10 + {28'd0, digit};
      end
      if (widened[35:32] != 4'd0) begin
        settle_result(ST_OVERFLOW, '0, '0, '0, last, res);
        return 1'b1;
      end
      if (parse_phase == PH_FIRST) begin
        context_acc = widened[31:0];
      end else begin
        message_acc = widened[31:0];
      end
    end else begin
      settle_result(ST_BAD_CHAR, '0, '0, '0, last, res);
      return 1'b1;
    end
    if (last) begin
      settle_result(ST_INCOMPLETE, '0, '0, '0, 1'b1, res);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string field_name, input logic [31:0] expected_value,
                                      input logic [31:0] actual_value);
    if (actual_value !== expected_value) begin
      $error("%s mismatch: expected %0d, actual %0d", field_name, expected_value,
             actual_value);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t predicted;
    result_t oldest;
    if (!rst_ni) begin
      clear_parse_state();
      pending_results.delete();
    end else begin
      // The result beat is checked before this edge's input beat is predicted,
      // since a byte can never settle its own result at the edge it is taken.
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: status %0d, context %0d, message %0d, header %0d",
                 status_i, context_length_i, message_length_i, header_length_i);
          fail_count_o++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("status", 32'(oldest.status), 32'(status_i));
          check_field("context_length", oldest.context_length, context_length_i);
          check_field("message_length", oldest.message_length, message_length_i);
          check_field("header_length", 32'(oldest.header_length), 32'(header_length_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (parse_header_byte(data_byte_i, end_of_buffer_i, predicted)) begin
          pending_results.insert(pending_results.size(), predicted);
        end
      end
    end
    pending_count_o = pending_results.size();
  end

endmodule : header_parse_monitor

### tb/decimal_length_header_parser_unit_test.sv
// ----------------------------------------------------------------------------
// Decimal length header parser unit test
// Feeds directed and random buffers into the header parser under several
// sender and receiver idling patterns; the monitor beside the block predicts
// and checks every result beat, and this top gives the verdict.
// ----------------------------------------------------------------------------
module decimal_length_header_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dlhp_pkg::*;

  localparam int unsigned MAX_BUFFER_BYTES = 65536;
  localparam int          RANDOM_BYTES     = 950;
  localparam int          CYCLE_LIMIT      = 2_000_000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i     = 8'h00;
  logic        end_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] context_length_o;
  logic [31:0] message_length_o;
  logic [16:0] header_length_o;

  int          fail_count;
  int          pending_count;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic [7:0]  frame_bytes[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  decimal_length_header_parser_unit #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .context_length_o(context_length_o),
    .message_length_o(message_length_o),
    .header_length_o (header_length_o)
  );

  header_parse_monitor #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .context_length_i(context_length_o),
    .message_length_i(message_length_o),
    .header_length_i (header_length_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] value);
    frame_bytes.insert(frame_bytes.size(), value);
  endfunction

  function automatic void add_text(input string text);
    for (int i = 0; i < text.len(); i++) add_byte(text[i]);
  endfunction

  function automatic void add_repeated(input logic [7:0] value, input int count);
    repeat (count) add_byte(value);
  endfunction

  function automatic void add_random_bytes(input int count);
    repeat (count) add_byte(8'($urandom_range(255)));
  endfunction

  // Decimal digits with occasional leading zeros and stray carriage returns.
  function automatic void add_number(input longint unsigned value);
    string digits;
    digits = $sformatf("%0d", value);
    if ($urandom_range(9) == 0) add_repeated(CH_ZERO, $urandom_range(1, 3));
    for (int i = 0; i < digits.len(); i++) begin
      if ($urandom_range(15) == 0) add_byte(CH_CR);
      add_byte(digits[i]);
    end
  endfunction

  function automatic longint unsigned pick_length();
    case ($urandom_range(5))
      0:       return $urandom_range(9);
      1:       return $urandom_range(999);
      2:       return $urandom_range(999999);
      3:       return $urandom;
      4:       return 64'd4294967295 - $urandom_range(3);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic longint unsigned pick_overflow();
    case ($urandom_range(2))
      0:       return 64'd4294967296 + $urandom_range(1000);
      1:       return {31'd0, 1'b1, 32'($urandom)} + 64'd4294967296 * $urandom_range(1);
      default: return {32'($urandom), 32'($urandom)} | (64'd1 << 40);
    endcase
  endfunction

  function automatic void end_field();
    if ($urandom_range(4) == 0) add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic void add_first_field();
    longint unsigned ctx;
    ctx = pick_length();
    if (ctx == 0) ctx = 1;
    add_number(ctx);
    end_field();
  endfunction

  function automatic void add_header();
    add_first_field();
    add_number(pick_length());
    end_field();
  endfunction

  // Mostly well-formed headers with random content; the rest are broken
  // headers of every kind and plain noise.
  function automatic void build_random_frame();
    int         kind;
    int         spot;
    logic [7:0] bad;
    frame_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 60) begin
      add_header();
      add_random_bytes($urandom_range(6));
    end else if (kind < 68) begin
      add_first_field();
      if ($urandom_range(1)) add_number(pick_length());
    end else if (kind < 76) begin
      add_header();
      spot = $urandom_range(frame_bytes.size() - 1);
      add_random_bytes($urandom_range(3));
      do begin
        bad = 8'($urandom_range(255));
      end while ((bad >= CH_ZERO && bad <= CH_NINE) || bad == CH_LF || bad == CH_CR);
      frame_bytes[spot] = bad;
    end else if (kind < 82) begin
      if ($urandom_range(1)) begin
        add_number(pick_overflow());
        end_field();
        add_number(pick_length());
      end else begin
        add_first_field();
        add_number(pick_overflow());
      end
      end_field();
      add_random_bytes($urandom_range(2));
    end else if (kind < 87) begin
      if ($urandom_range(1)) add_repeated(CH_CR, $urandom_range(1, 2));
      add_repeated(CH_ZERO, $urandom_range(1, 3));
      end_field();
      add_number(pick_length());
      end_field();
    end else if (kind < 91) begin
      add_byte(CH_LF);
      add_header();
    end else begin
      add_random_bytes($urandom_range(1, 8));
    end
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= value;
    end_of_buffer_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic run_directed();
    // Smallest legal header, with a zero message length.
    frame_bytes = {};
    add_text("1"); add_byte(CH_LF); add_text("0"); add_byte(CH_LF);
    send_frame();
    // Both fields at their largest, followed by payload.
    frame_bytes = {};
    add_text("4294967295"); add_byte(CH_LF);
    add_text("4294967295"); add_byte(CH_LF);
    add_random_bytes(4);
    send_frame();
    // One past the largest value, in each field.
    frame_bytes = {};
    add_text("4294967296"); add_byte(CH_LF); add_text("1");
    add_byte(CH_LF);
    send_frame();
    frame_bytes = {};
    add_text("12"); add_byte(CH_LF); add_text("4294967296");
    add_byte(CH_LF);
    send_frame();
    // Newline as the very first byte.
    frame_bytes = {};
    add_byte(CH_LF); add_text("5"); add_byte(CH_LF);
    send_frame();
    // Zero context, written out and as a line of carriage returns.
    frame_bytes = {};
    add_text("0"); add_byte(CH_LF); add_text("5"); add_byte(CH_LF);
    send_frame();
    frame_bytes = {};
    add_repeated(CH_CR, 2); add_byte(CH_LF); add_text("5");
    add_byte(CH_LF);
    send_frame();
    // Bad characters, with trailing bytes to be swallowed.
    frame_bytes = {};
    add_text("12a"); add_byte(CH_LF); add_text("3");
    add_random_bytes(3);
    send_frame();
    frame_bytes = {};
    add_text("3"); add_byte(CH_LF); add_text("4/"); add_byte(CH_LF);
    send_frame();
    frame_bytes = {};
    add_text("8:");
    send_frame();
    // Buffers ending inside the second field and right after the first newline.
    frame_bytes = {};
    add_text("12"); add_byte(CH_LF); add_text("34");
    send_frame();
    frame_bytes = {};
    add_text("12"); add_byte(CH_LF);
    send_frame();
    frame_bytes = {};
    add_text("5"); add_byte(CH_LF); add_text("6"); add_byte(CH_CR);
    send_frame();
    // Carriage returns before each newline and leading zeros.
    frame_bytes = {};
    add_text("1"); add_byte(CH_CR); add_byte(CH_LF);
    add_text("2"); add_byte(CH_CR); add_byte(CH_LF);
    add_random_bytes(3);
    send_frame();
    frame_bytes = {};
    add_text("00012"); add_byte(CH_LF); add_text("000");
    add_byte(CH_LF);
    send_frame();
    // Single-byte buffers.
    frame_bytes = {8'h37};
    send_frame();
    frame_bytes = {8'hFF};
    send_frame();
    frame_bytes = {CH_LF};
    send_frame();
  endtask

  initial begin
    int random_bytes_sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int idle_mode = 0; idle_mode < 4; idle_mode++) begin
      case (idle_mode)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 50;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 50;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct    <= 30;
        end
      endcase
      if (idle_mode == 0) run_directed();
      random_bytes_sent = 0;
      while (random_bytes_sent < RANDOM_BYTES / 4) begin
        build_random_frame();
        send_frame();
        random_bytes_sent += frame_bytes.size();
      end
    end
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : decimal_length_header_parser_unit_test

### sim.f
hdl/dlhp_pkg.sv
hdl/dlhp_front.sv
hdl/dlhp_queue.sv
hdl/dlhp_back.sv
hdl/decimal_length_header_parser_unit.sv
tb/header_parse_monitor.sv
tb/decimal_length_header_parser_unit_test.sv
